// File: rtl/bsc_pkg.sv
// Shared types, constants and the divider step for the compensation core.
`default_nettype none
package bsc_pkg;

   localparam int DivBits = 64;
   localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
   localparam logic [20:0] PRESS_BASE = 21'h100000;
   localparam logic [11:0] NUM_SCALE = 12'd3125;
   localparam logic [63:0] X1_BIAS = 64'h0000_8000_0000_0000;
   localparam logic [31:0] ROUND_HALF = 32'd128;

   typedef enum logic [1:0] {
      CSR_TEMP,
      CSR_PRESS_A,
      CSR_PRESS_B,
      CSR_PRESS_C
   } csr_index_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [47:0] press_a;
      logic [47:0] press_b;
      logic [47:0] press_c;
   } coef_type;

   typedef struct packed {
      logic [31:0] temp_centi;
      logic [31:0] fine;
      logic [19:0] raw_press;
   } side_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [DivBits-1:0] word;
      logic [30:0] den;
      logic neg;
      logic invalid;
      side_type side;
   } div_type;

   // one restoring step: numerator bits leave the top of word, quotient bits enter the bottom
   function automatic div_type div_step(input div_type s);
      logic [31:0] r2;
      div_type o;
      o = s;
      r2 = {s.rem, s.word[DivBits-1]};
      if (r2 >= {1'b0, s.den}) begin
         o.rem = 31'(r2 - {1'b0, s.den});
         o.word = {s.word[DivBits-2:0], 1'b1};
      end else begin
         o.rem = r2[30:0];
         o.word = {s.word[DivBits-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// File: rtl/baro_sensor_compensation_core.sv
// Pipeline from req acceptance to rsp_valid: temperature path, pressure front end, divider,
//   back end and output register. Throughput: one item per cycle while rsp is not stalled.
// The 64-stage divider pipeline (one quotient bit per stage) sets the latency.
// All stages advance together; a stalled rsp item freezes the whole pipeline.
// Reset (synchronous): all valid bits cleared, coefficient registers to zero.
// Coefficient registers are read directly by the stages, so a write affects items in flight; write only while idle.
`default_nettype none
module baro_sensor_compensation_core import bsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic signed [31:0] rsp_fine_temperature,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_pressure_invalid,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_write_data
);

   // coefficient registers
   coef_type coef_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP:    coef_ff.temp <= csr_write_data;
            CSR_PRESS_A: coef_ff.press_a <= csr_write_data;
            CSR_PRESS_B: coef_ff.press_b <= csr_write_data;
            CSR_PRESS_C: coef_ff.press_c <= csr_write_data;
            default:     coef_ff <= coef_ff;
         endcase
      end
   end

   // global advance: the output register is empty or being drained
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic t_valid, f_valid, d_valid, b_valid;
   side_type t_side, b_side;
   div_type f_div, d_div;
   logic [31:0] b_press;
   logic b_invalid;

   bsc_temp u_temp (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .in_valid        (req_valid),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .coef            (coef_ff),
      .out_valid       (t_valid),
      .side_out        (t_side)
   );

   bsc_pfront u_pfront (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t_valid),
      .side_in   (t_side),
      .coef      (coef_ff),
      .out_valid (f_valid),
      .div_out   (f_div)
   );

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (f_valid),
      .div_in    (f_div),
      .out_valid (d_valid),
      .div_out   (d_div)
   );

   bsc_pback u_pback (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d_valid),
      .div_in    (d_div),
      .coef      (coef_ff),
      .out_valid (b_valid),
      .side_out  (b_side),
      .pressure  (b_press),
      .invalid   (b_invalid)
   );

   // output register
   logic [31:0] tc_ff, fine_ff, press_ff;
   logic inv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff <= b_side.temp_centi;
         fine_ff <= b_side.fine;
         press_ff <= b_press;
         inv_ff <= b_invalid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_temperature_centi = tc_ff;
   assign rsp_fine_temperature = fine_ff;
   assign rsp_pressure_q24_8 = press_ff;
   assign rsp_pressure_invalid = inv_ff;

   // a zero divisor always reports zero pressure
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure_q24_8 == 32'd0)
      else $error("invalid pressure item with nonzero value");

   // a held result blocks new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while output stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule
`default_nettype wire

// File: rtl/bsc_temp.sv
// Temperature path: fine temperature and hundredths of a degree, four stages.
`default_nettype none
module bsc_temp import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [19:0] raw_temperature,
   input  logic [19:0] raw_pressure,
   input  coef_type    coef,
   output logic        out_valid,
   output side_type    side_out
);

   logic [15:0] t1;
   logic signed [15:0] t2, t3;
   assign t1 = coef.temp[15:0];
   assign t2 = $signed(coef.temp[31:16]);
   assign t3 = $signed(coef.temp[47:32]);

   logic [3:0] vld_ff;

   // stage 1
   logic signed [17:0] a_in, d_in;
   logic signed [33:0] at2_in;
   logic signed [35:0] dd_in;
   logic [31:0] at2_ff, dd_ff;
   logic [19:0] rp1_ff, rp2_ff, rp3_ff;
   assign a_in = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign d_in = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, t1});
   assign at2_in = a_in * t2;
   assign dd_in = d_in * d_in;

   // stage 2
   logic signed [31:0] v1_in, d2_in;
   logic signed [35:0] dt3_in;
   logic [31:0] v1_ff, dt3_ff;
   assign v1_in = $signed(at2_ff) >>> 11;
   assign d2_in = $signed(dd_ff) >>> 12;
   assign dt3_in = $signed(d2_in[19:0]) * t3;

   // stage 3
   logic signed [31:0] v2_w;
   logic [31:0] fine_in, fine_ff;
   assign v2_w = $signed(dt3_ff) >>> 14;
   assign fine_in = v1_ff + v2_w;

   // stage 4: (fine * 5 + 128) >>> 8
   logic [31:0] f5_w;
   logic signed [31:0] tc_in;
   assign f5_w = {fine_ff[29:0], 2'b0} + fine_ff + ROUND_HALF;
   assign tc_in = $signed(f5_w) >>> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         at2_ff <= at2_in[31:0];
         dd_ff <= dd_in[31:0];
         rp1_ff <= raw_pressure;
         v1_ff <= v1_in;
         dt3_ff <= dt3_in[31:0];
         rp2_ff <= rp1_ff;
         fine_ff <= fine_in;
         rp3_ff <= rp2_ff;
         side_out.temp_centi <= tc_in;
         side_out.fine <= fine_ff;
         side_out.raw_press <= rp3_ff;
      end
   end

   assign out_valid = vld_ff[3];

endmodule
`default_nettype wire

// File: rtl/bsc_pfront.sv
// Pressure front end: numerator and divisor in sign-magnitude form, six stages.
`default_nettype none
module bsc_pfront import bsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  side_type side_in,
   input  coef_type coef,
   output logic     out_valid,
   output div_type  div_out
);

   logic [15:0] p1;
   logic signed [15:0] p2, p3, p4, p5, p6;
   assign p1 = coef.press_a[15:0];
   assign p2 = $signed(coef.press_a[31:16]);
   assign p3 = $signed(coef.press_a[47:32]);
   assign p4 = $signed(coef.press_b[15:0]);
   assign p5 = $signed(coef.press_b[31:16]);
   assign p6 = $signed(coef.press_b[47:32]);

   logic [5:0] vld_ff;
   side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;

   // F1: x1 = fine - 128000, square and the two linear products
   logic signed [32:0] x1_in;
   logic signed [65:0] sq_in;
   logic signed [48:0] x1p5_in, x1p2_in;
   logic [20:0] pp_in;
   logic [63:0] sq_ff;
   logic [48:0] x1p5_ff, x1p2_ff;
   logic [20:0] pp1_ff, pp2_ff, pp3_ff;
   assign x1_in = $signed({side_in.fine[31], side_in.fine}) - FINE_OFFSET;
   assign sq_in = x1_in * x1_in;
   assign x1p5_in = x1_in * p5;
   assign x1p2_in = x1_in * p2;
   assign pp_in = PRESS_BASE - {1'b0, side_in.raw_press};

   // F2: square times p6 and p3, low 64 bits from two half products each
   logic signed [48:0] lo6_w, lo3_w;
   logic signed [47:0] hi6_w, hi3_w;
   logic [63:0] x2a_in, x3a_in, x2a_ff, x3a_ff;
   logic [48:0] x1p5b_ff, x1p2b_ff;
   assign lo6_w = $signed({1'b0, sq_ff[31:0]}) * p6;
   assign hi6_w = $signed(sq_ff[63:32]) * p6;
   assign lo3_w = $signed({1'b0, sq_ff[31:0]}) * p3;
   assign hi3_w = $signed(sq_ff[63:32]) * p3;
   assign x2a_in = {{15{lo6_w[48]}}, lo6_w} + {hi6_w[31:0], 32'b0};
   assign x3a_in = {{15{lo3_w[48]}}, lo3_w} + {hi3_w[31:0], 32'b0};

   // F3: sums
   logic signed [63:0] x3s_w;
   logic [63:0] x2_in, x1b_in, x2_ff, x1b_ff;
   assign x3s_w = $signed(x3a_ff) >>> 8;
   assign x2_in = x2a_ff + ({{15{x1p5b_ff[48]}}, x1p5b_ff} << 17)
                + ({{48{p4[15]}}, p4} << 35);
   assign x1b_in = x3s_w + ({{15{x1p2b_ff[48]}}, x1p2b_ff} << 12);

   // F4
   logic [63:0] nump_in, y_in, nump_ff, y_ff;
   assign nump_in = {12'b0, pp3_ff, 31'b0} - x2_ff;
   assign y_in = x1b_ff + X1_BIAS;

   // F5: scale numerator, multiply divisor term by p1
   logic [43:0] nlo_w;
   logic [31:0] nhi_w, yhi_w;
   logic [47:0] ylo_w;
   logic [63:0] num_in, x1c_in, num_ff, x1c_ff;
   assign nlo_w = nump_ff[31:0] * NUM_SCALE;
   assign nhi_w = nump_ff[63:32] * {20'b0, NUM_SCALE};
   assign ylo_w = y_ff[31:0] * p1;
   assign yhi_w = y_ff[63:32] * {16'b0, p1};
   assign num_in = {20'b0, nlo_w} + {nhi_w, 32'b0};
   assign x1c_in = {16'b0, ylo_w} + {yhi_w, 32'b0};

   // F6: divisor = x1c >>> 33, then magnitudes and quotient sign
   logic [30:0] den_w;
   div_type d_in;
   assign den_w = x1c_ff[63:33];
   always_comb begin
      d_in.rem = '0;
      d_in.word = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      d_in.den = den_w[30] ? (31'd0 - den_w) : den_w;
      d_in.neg = num_ff[63] ^ den_w[30];
      d_in.invalid = (den_w == 31'd0);
      d_in.side = s5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in[63:0];
         x1p5_ff <= x1p5_in;
         x1p2_ff <= x1p2_in;
         pp1_ff <= pp_in;
         s1_ff <= side_in;
         x2a_ff <= x2a_in;
         x3a_ff <= x3a_in;
         x1p5b_ff <= x1p5_ff;
         x1p2b_ff <= x1p2_ff;
         pp2_ff <= pp1_ff;
         s2_ff <= s1_ff;
         x2_ff <= x2_in;
         x1b_ff <= x1b_in;
         pp3_ff <= pp2_ff;
         s3_ff <= s2_ff;
         nump_ff <= nump_in;
         y_ff <= y_in;
         s4_ff <= s3_ff;
         num_ff <= num_in;
         x1c_ff <= x1c_in;
         s5_ff <= s4_ff;
         div_out <= d_in;
      end
   end

   assign out_valid = vld_ff[5];

endmodule
`default_nettype wire

// File: rtl/bsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module bsc_div import bsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type div_in,
   output logic    out_valid,
   output div_type div_out
);

   logic [DivBits-1:0] vld_ff;
   div_type st_ff [DivBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DivBits-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= div_step(div_in);
      end
   end

   for (genvar k = 1; k < DivBits; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= div_step(st_ff[k-1]);
         end
      end
   end

   assign out_valid = vld_ff[DivBits-1];
   assign div_out = st_ff[DivBits-1];

endmodule
`default_nettype wire

// File: rtl/bsc_pback.sv
// Pressure back end: quotient sign, p9/p8 corrections and final scaling.
`default_nettype none
module bsc_pback import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  div_type     div_in,
   input  coef_type    coef,
   output logic        out_valid,
   output side_type    side_out,
   output logic [31:0] pressure,
   output logic        invalid
);

   logic signed [15:0] p7, p8, p9;
   assign p7 = $signed(coef.press_c[15:0]);
   assign p8 = $signed(coef.press_c[31:16]);
   assign p9 = $signed(coef.press_c[47:32]);

   logic [3:0] vld_ff;
   side_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic inv1_ff, inv2_ff, inv3_ff, inv4_ff;

   // B1: signed quotient
   logic [63:0] p_in, p1_ff, p2_ff, p3_ff;
   assign p_in = div_in.neg ? (64'd0 - div_in.word) : div_in.word;

   // B2: s = p >>> 13, s*s in halves; p8 * p in halves
   logic signed [63:0] s_w;
   logic [63:0] ll_in, ll_ff;
   logic [31:0] lh_in, lh_ff;
   logic signed [48:0] p8lo_in;
   logic signed [47:0] p8hi_in;
   logic [48:0] p8lo_ff;
   logic [31:0] p8hi_ff;
   assign s_w = $signed(p1_ff) >>> 13;
   assign ll_in = s_w[31:0] * s_w[31:0];
   assign lh_in = s_w[31:0] * s_w[63:32];
   assign p8lo_in = $signed({1'b0, p1_ff[31:0]}) * p8;
   assign p8hi_in = $signed(p1_ff[63:32]) * p8;

   // B3
   logic [63:0] v_in, v_ff, x8_w;
   logic signed [63:0] x2_in;
   logic [63:0] x2_ff;
   assign v_in = ll_ff + {lh_ff[30:0], 33'b0};
   assign x8_w = {{15{p8lo_ff[48]}}, p8lo_ff} + {p8hi_ff, 32'b0};
   assign x2_in = $signed(x8_w) >>> 19;

   // B4: v * p9 in halves
   logic signed [48:0] vlo_in;
   logic signed [47:0] vhi_in;
   logic [48:0] vlo_ff;
   logic [31:0] vhi_ff;
   logic [63:0] sum0_in, sum0_ff;
   assign vlo_in = $signed({1'b0, v_ff[31:0]}) * p9;
   assign vhi_in = $signed(v_ff[63:32]) * p9;
   assign sum0_in = p3_ff + x2_ff;

   // output side: ((p + x1 + x2) >>> 8) + (p7 << 4), low 32 bits
   logic [63:0] vp9_w, tot_w;
   logic signed [63:0] x1_w;
   assign vp9_w = {{15{vlo_ff[48]}}, vlo_ff} + {vhi_ff, 32'b0};
   assign x1_w = $signed(vp9_w) >>> 25;
   assign tot_w = sum0_ff + x1_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p_in;
         s1_ff <= div_in.side;
         inv1_ff <= div_in.invalid;
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         p8lo_ff <= p8lo_in;
         p8hi_ff <= p8hi_in[31:0];
         p2_ff <= p1_ff;
         s2_ff <= s1_ff;
         inv2_ff <= inv1_ff;
         v_ff <= v_in;
         x2_ff <= x2_in;
         p3_ff <= p2_ff;
         s3_ff <= s2_ff;
         inv3_ff <= inv2_ff;
         vlo_ff <= vlo_in;
         vhi_ff <= vhi_in[31:0];
         sum0_ff <= sum0_in;
         s4_ff <= s3_ff;
         inv4_ff <= inv3_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign side_out = s4_ff;
   assign invalid = inv4_ff;
   assign pressure = inv4_ff ? 32'd0 : (tot_w[39:8] + {{12{p7[15]}}, p7, 4'b0});

endmodule
`default_nettype wire
